### src/hadc_pkg.sv
// ----------------------------------------------------------------------------
// hadc_pkg
// Shared types, constants and helpers of the Hijri absolute day converter.
// ----------------------------------------------------------------------------
package hadc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ABS_W   = 22;
  localparam int WDAY_W  = 3;
  localparam int REG_W   = 10;
  localparam int DVD_W   = 32;
  localparam int DVS_W   = 15;
  localparam int ACC_W   = 26;

  localparam logic [1:0] REG_EPOCH  = 2'd0;
  localparam logic [1:0] REG_NUM    = 2'd1;
  localparam logic [1:0] REG_DEN    = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  localparam logic CMD_TO_ABS  = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  typedef struct packed {
    logic [ABS_W-1:0] epoch;
    logic [REG_W-1:0] num;
    logic [REG_W-1:0] den;     // effective: zero reads as 12
    logic [REG_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic               pre_epoch;  // day-to-date item that lies before the epoch
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  year_eff;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [ABS_W-1:0]   abs_day;
  } item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [ABS_W-1:0]   abs_day;
    logic [WDAY_W-1:0]  weekday;
    logic               pre_epoch;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // 8 = 1 mod 7, so octal digit sums keep the residue
  function automatic logic [WDAY_W-1:0] mod7(input logic [ABS_W-1:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
       + 6'(v[17:15]) + 6'(v[20:18]) + 6'(v[21]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd14) begin
      return 3'd0;
    end else if (s2 >= 4'd7) begin
      return 3'(s2 - 4'd7);
    end else begin
      return s2[2:0];
    end
  endfunction

endpackage

### src/hadc_div.sv
// ----------------------------------------------------------------------------
// hadc_div
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ----------------------------------------------------------------------------
module hadc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hadc_pkg::div_req_t req,
  output hadc_pkg::div_rsp_t rsp
);
  import hadc_pkg::*;

  logic [DVD_W-1:0] a_r, a_nxt;
  logic [DVS_W-1:0] b_r, b_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, a_r[DVD_W-1]};
    if (req.start && !busy_r) begin
      a_nxt    = req.dividend;
      b_nxt    = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, b_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, b_r});
        a_nxt   = {a_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        a_nxt   = {a_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = a_r;
  assign rsp.rem  = rem_r;

endmodule

### src/hadc_front.sv
// ----------------------------------------------------------------------------
// hadc_front
// Input handshake and classification of incoming words.
// ----------------------------------------------------------------------------
module hadc_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [47:0]                       in_tdata,
  input  logic                              in_tuser,
  input  logic [hadc_pkg::ABS_W-1:0]        epoch,
  input  logic                              q_full,
  output logic                              q_push,
  output hadc_pkg::item_t                   q_item
);
  import hadc_pkg::*;

  always_comb begin
    q_item.cmd       = in_tuser;
    q_item.year      = in_tdata[13:0];
    q_item.month     = in_tdata[17:14];
    q_item.day       = in_tdata[22:18];
    q_item.abs_day   = in_tdata[44:23];
    // year zero is computed as year one
    q_item.year_eff  = (in_tdata[13:0] == '0) ? YEAR_W'(1) : in_tdata[13:0];
    q_item.pre_epoch = (in_tuser == CMD_TO_DATE) && (in_tdata[44:23] < epoch);
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

### src/hadc_queue.sv
// ----------------------------------------------------------------------------
// hadc_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module hadc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hadc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hadc_pkg::item_t pop_item
);
  import hadc_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];

endmodule

### src/hadc_back.sv
// ----------------------------------------------------------------------------
// hadc_back
// Conversion sequencer: divisions on the shared divider, month-by-month
// summation, and the result register.
// ----------------------------------------------------------------------------
module hadc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hadc_pkg::cfg_t     cfg,
  input  logic               q_not_empty,
  input  hadc_pkg::item_t    q_item,
  output logic               q_pop,
  output hadc_pkg::div_req_t div_req,
  input  hadc_pkg::div_rsp_t div_rsp,
  output logic               res_valid,
  input  logic               res_ready,
  output hadc_pkg::res_t     res
);
  import hadc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PMOD = 5'd1;
  localparam logic [4:0] S_EMUL = 5'd2;
  localparam logic [4:0] S_EDIV = 5'd3;
  localparam logic [4:0] S_E12  = 5'd4;
  localparam logic [4:0] S_DQ   = 5'd5;
  localparam logic [4:0] S_DMC  = 5'd6;
  localparam logic [4:0] S_DACC = 5'd7;
  localparam logic [4:0] S_DR12 = 5'd8;
  localparam logic [4:0] S_DQP  = 5'd9;
  localparam logic [4:0] S_DR0  = 5'd10;
  localparam logic [4:0] S_DYL  = 5'd11;
  localparam logic [4:0] S_DR1  = 5'd12;
  localparam logic [4:0] S_DML  = 5'd13;
  localparam logic [4:0] S_DFIN = 5'd14;
  localparam logic [4:0] S_CLEN = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  // ceil(2^21 / 12)
  localparam logic [17:0] RECIP12 = 18'd174763;

  logic [4:0]         state_r, state_nxt;
  logic               pend_r, pend_nxt;
  item_t              it_r, it_nxt;
  logic [YEAR_W-1:0]  y_r, y_nxt;
  logic [MONTH_W-1:0] m_r, m_nxt;
  logic [DAY_W-1:0]   d_r, d_nxt;
  logic [REG_W-1:0]   pm_r, pm_nxt;
  logic [REG_W-1:0]   r_r, r_nxt;
  logic [DVD_W-1:0]   big_r, big_nxt;
  logic [17:0]        mc_r, mc_nxt;
  logic [17:0]        qc_r, qc_nxt;
  logic [17:0]        mcc_r, mcc_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [17:0]        cnt_r, cnt_nxt;
  res_t               pend_res_r, pend_res_nxt;
  res_t               res_r, res_nxt;
  logic               valid_r, valid_nxt;

  logic               div_state;
  logic [22:0]        est_diff;
  logic [32:0]        est_prod;
  logic [DVS_W-1:0]   est_den;
  logic [17:0]        months_y;
  logic [10:0]        off1;
  logic [20:0]        r0_prod;
  logic [18:0]        n_base;
  logic [28:0]        n_prod;
  logic [18:0]        n_prev;
  logic [28:0]        p_prod;
  logic [27:0]        mcc_prod;
  logic [27:0]        qp_prod;
  logic [22:0]        mcc29;
  logic [4:0]         len_cur;
  logic [10:0]        r_step;
  logic [ACC_W-1:0]   acc_fin;
  logic [ACC_W-1:0]   d0_adj;
  logic [YEAR_W-1:0]  yrest;
  logic [17:0]        d12_in;
  logic [35:0]        d12_prod;
  logic [14:0]        d12_q;
  logic [17:0]        d12_r;

  always_comb begin
    est_diff = {1'b0, it_r.abs_day} - {1'b0, cfg.epoch} + 23'd1;
    est_prod = 33'(est_diff) * 33'(cfg.den);
    est_den  = DVS_W'(cfg.den) * DVS_W'(29) + DVS_W'(cfg.num);
    months_y = (18'(y_r) - 18'd1) * 18'd12;
    off1     = 11'(cfg.offset) + 11'd1;
    r0_prod  = 21'(off1) * 21'(cfg.num);
    n_base   = 19'(months_y) + 19'd1 + 19'(cfg.offset);
    n_prod   = 29'(n_base) * 29'(cfg.num);
    // corrected month count plus offset; the offset for year zero, month 12
    n_prev   = 19'(y_r) * 19'd12 + 19'(m_r) - 19'd12 + 19'(cfg.offset);
    p_prod   = 29'(n_prev) * 29'(cfg.num);
    mcc_prod = 28'(qc_r) * 28'(cfg.den);
    qp_prod  = 28'(qc_r) * 28'(cfg.num);
    mcc29    = 23'(mcc_r) * 23'd29;
    len_cur  = (r_r < cfg.num) ? 5'd30 : 5'd29;
    r_step   = 11'(r_r) + 11'(pm_r);
    if (r_step >= 11'(cfg.den)) r_step = r_step - 11'(cfg.den);
    acc_fin  = acc_r + ACC_W'(d_r) - ACC_W'(1);
    d0_adj   = acc_r - ((div_rsp.rem < DVS_W'(cfg.num)) ? ACC_W'(30) : ACC_W'(29));
    // x / 12 by reciprocal multiply, exact for x below 2^19
    d12_in   = (state_r == S_E12) ? mc_r : mcc_r;
    d12_prod = 36'(d12_in) * 36'(RECIP12);
    d12_q    = d12_prod[35:21];
    d12_r    = d12_in - 18'(d12_q) * 18'd12;
    yrest    = y_r - d12_q[YEAR_W-1:0] - YEAR_W'(1);
  end

  always_comb begin
    div_state = state_r inside {S_PMOD, S_EDIV, S_DQ, S_DR0, S_DR1, S_CLEN};
    div_req.start = div_state && !pend_r;
    case (state_r)
      S_PMOD:  begin
        div_req.dividend = DVD_W'(cfg.num);
        div_req.divisor  = DVS_W'(cfg.den);
      end
      S_EDIV:  begin
        div_req.dividend = big_r;
        div_req.divisor  = est_den;
      end
      S_DQ:    begin
        div_req.dividend = DVD_W'(months_y);
        div_req.divisor  = DVS_W'(cfg.den);
      end
      S_DR0:   begin
        div_req.dividend = DVD_W'(r0_prod);
        div_req.divisor  = DVS_W'(cfg.den);
      end
      S_DR1:   begin
        div_req.dividend = DVD_W'(n_prod);
        div_req.divisor  = DVS_W'(cfg.den);
      end
      S_CLEN:  begin
        div_req.dividend = DVD_W'(p_prod);
        div_req.divisor  = DVS_W'(cfg.den);
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = DVS_W'(12);
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    it_nxt       = it_r;
    y_nxt        = y_r;
    m_nxt        = m_r;
    d_nxt        = d_r;
    pm_nxt       = pm_r;
    r_nxt        = r_r;
    big_nxt      = big_r;
    mc_nxt       = mc_r;
    qc_nxt       = qc_r;
    mcc_nxt      = mcc_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    pend_res_nxt = pend_res_r;
    res_nxt      = res_r;
    valid_nxt    = valid_r && !res_ready;
    q_pop        = 1'b0;

    if (div_state && !pend_r) pend_nxt = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop  = 1'b1;
          it_nxt = q_item;
          if (q_item.pre_epoch) begin
            pend_res_nxt.year      = '0;
            pend_res_nxt.month     = '0;
            pend_res_nxt.day       = '0;
            pend_res_nxt.abs_day   = q_item.abs_day;
            pend_res_nxt.pre_epoch = 1'b1;
            state_nxt              = S_OUT;
          end else begin
            state_nxt = S_PMOD;
          end
        end
      end
      S_PMOD: begin
        if (pend_r && div_rsp.done) begin
          pend_nxt = 1'b0;
          pm_nxt   = div_rsp.rem[REG_W-1:0];
          if (it_r.cmd == CMD_TO_ABS) begin
            y_nxt     = it_r.year_eff;
            m_nxt     = it_r.month;
            d_nxt     = it_r.day;
            state_nxt = S_DQ;
          end else begin
            state_nxt = S_EMUL;
          end
        end
      end
      S_EMUL: begin
        big_nxt   = est_prod[DVD_W-1:0];
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        if (pend_r && div_rsp.done) begin
          pend_nxt  = 1'b0;
          mc_nxt    = div_rsp.quot[17:0];
          state_nxt = S_E12;
        end
      end
      S_E12: begin
        y_nxt     = d12_q[YEAR_W-1:0] + YEAR_W'(1);
        m_nxt     = d12_r[MONTH_W-1:0] + MONTH_W'(1);
        d_nxt     = DAY_W'(1);
        state_nxt = S_DQ;
      end
      S_DQ: begin
        if (pend_r && div_rsp.done) begin
          pend_nxt  = 1'b0;
          qc_nxt    = div_rsp.quot[17:0];
          state_nxt = S_DMC;
        end
      end
      S_DMC: begin
        mcc_nxt   = mcc_prod[17:0];
        state_nxt = S_DACC;
      end
      S_DACC: begin
        acc_nxt   = ACC_W'(cfg.epoch) + ACC_W'(mcc29);
        state_nxt = S_DR12;
      end
      S_DR12: begin
        // whole years left over past the closed-form cycles
        cnt_nxt   = 18'(yrest) * 18'd12;
        state_nxt = S_DQP;
      end
      S_DQP: begin
        acc_nxt   = acc_r + qp_prod[ACC_W-1:0];
        state_nxt = S_DR0;
      end
      S_DR0: begin
        if (pend_r && div_rsp.done) begin
          pend_nxt  = 1'b0;
          r_nxt     = div_rsp.rem[REG_W-1:0];
          state_nxt = S_DYL;
        end
      end
      S_DYL: begin
        if (cnt_r == '0) begin
          state_nxt = S_DR1;
        end else begin
          acc_nxt = acc_r + ACC_W'(len_cur);
          r_nxt   = r_step[REG_W-1:0];
          cnt_nxt = cnt_r - 18'd1;
        end
      end
      S_DR1: begin
        if (pend_r && div_rsp.done) begin
          pend_nxt  = 1'b0;
          r_nxt     = div_rsp.rem[REG_W-1:0];
          cnt_nxt   = (m_r == '0) ? '0 : 18'(m_r - MONTH_W'(1));
          state_nxt = S_DML;
        end
      end
      S_DML: begin
        if (cnt_r == '0) begin
          state_nxt = S_DFIN;
        end else begin
          acc_nxt = acc_r + ACC_W'(len_cur);
          r_nxt   = r_step[REG_W-1:0];
          cnt_nxt = cnt_r - 18'd1;
        end
      end
      S_DFIN: begin
        if (it_r.cmd == CMD_TO_ABS) begin
          pend_res_nxt.year      = it_r.year;
          pend_res_nxt.month     = it_r.month;
          pend_res_nxt.day       = it_r.day;
          pend_res_nxt.abs_day   = acc_fin[ABS_W-1:0];
          pend_res_nxt.pre_epoch = acc_fin[ABS_W-1:0] < cfg.epoch;
          state_nxt              = S_OUT;
        end else if (ACC_W'(it_r.abs_day) < acc_fin) begin
          // estimate overshot: step back one month
          acc_nxt = acc_fin;
          if (m_r == MONTH_W'(1)) begin
            y_nxt = y_r - YEAR_W'(1);
            m_nxt = MONTH_W'(12);
          end else begin
            m_nxt = m_r - MONTH_W'(1);
          end
          state_nxt = S_CLEN;
        end else begin
          pend_res_nxt.year      = y_r;
          pend_res_nxt.month     = m_r;
          pend_res_nxt.day       = DAY_W'(ACC_W'(it_r.abs_day) + ACC_W'(1) - acc_fin);
          pend_res_nxt.abs_day   = it_r.abs_day;
          pend_res_nxt.pre_epoch = 1'b0;
          state_nxt              = S_OUT;
        end
      end
      S_CLEN: begin
        if (pend_r && div_rsp.done) begin
          pend_nxt               = 1'b0;
          pend_res_nxt.year      = y_r;
          pend_res_nxt.month     = m_r;
          pend_res_nxt.day       = DAY_W'(ACC_W'(it_r.abs_day) + ACC_W'(1) - d0_adj);
          pend_res_nxt.abs_day   = it_r.abs_day;
          pend_res_nxt.pre_epoch = 1'b0;
          state_nxt              = S_OUT;
        end
      end
      S_OUT: begin
        if (!valid_r || res_ready) begin
          res_nxt         = pend_res_r;
          res_nxt.weekday = mod7(pend_res_r.abs_day);
          valid_nxt       = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
    it_r       <= it_nxt;
    y_r        <= y_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    pm_r       <= pm_nxt;
    r_r        <= r_nxt;
    big_r      <= big_nxt;
    mc_r       <= mc_nxt;
    qc_r       <= qc_nxt;
    mcc_r      <= mcc_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    pend_res_r <= pend_res_nxt;
    res_r      <= res_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

### src/hijri_absolute_day_converter.sv
// ----------------------------------------------------------------------------
// hijri_absolute_day_converter
// Converts between absolute day numbers and tabular Hijri dates.
// ----------------------------------------------------------------------------
// Input word: in_tuser selects the command (0 date to day, 1 day to date),
// in_tdata carries year, month, day and absolute day. Output word: the date,
// absolute day and weekday in out_tdata, the before-epoch flag in out_tuser.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle, which the block itself does not enforce.
// A two-entry queue sits between input and the sequencer, so up to two
// words are taken while the sequencer is busy or the output is stalled.
// Items are handled one at a time. Each division by a register value uses
// the shared bit-serial divider; date to day uses four of them, day to date
// five or six. Division by 12 is a combinational reciprocal multiply.
// On top, the months are summed one per cycle: up to about den + 24 months
// (leftover years of the partial cycle plus the month itself). A day before
// the epoch skips the conversion and goes straight to the output.
// A stalled output holds its word; the sequencer waits with the next result.
// Reset (rst_n low, synchronous) empties the queue, clears the output valid
// and loads the default registers.
// ----------------------------------------------------------------------------
module hijri_absolute_day_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // in_year, in_month, in_day, in_abs_day, zero pad
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_year, out_month, out_day, out_abs_day, weekday
  output logic        out_tuser   // before_epoch
);
  import hadc_pkg::*;

  logic [ABS_W-1:0] epoch_r;
  logic [REG_W-1:0] num_r, den_r, offset_r;
  cfg_t             cfg;
  logic             q_full, q_push, q_pop, q_not_empty;
  item_t            push_item, pop_item;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r  <= ABS_W'(227015);
      num_r    <= REG_W'(191);
      den_r    <= REG_W'(360);
      offset_r <= REG_W'(48);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EPOCH:  epoch_r  <= cfg_wdata;
        REG_NUM:    num_r    <= cfg_wdata[REG_W-1:0];
        REG_DEN:    den_r    <= cfg_wdata[REG_W-1:0];
        REG_OFFSET: offset_r <= cfg_wdata[REG_W-1:0];
        default:    epoch_r  <= epoch_r;
      endcase
    end
  end

  assign cfg.epoch  = epoch_r;
  assign cfg.num    = num_r;
  assign cfg.den    = (den_r == '0) ? REG_W'(12) : den_r;
  assign cfg.offset = offset_r;

  hadc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .epoch     (epoch_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  hadc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  hadc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hadc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {res.weekday, res.abs_day, res.day, res.month, res.year};
  assign out_tuser = res.pre_epoch;

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:45] != 3'd7)
    else $error("weekday out of range");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_req.start && div_rsp.busy))
    else $error("divider started while busy");

  a_div_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> $past(div_rsp.busy))
    else $error("divider done without a run");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Hijri absolute day converter. A queue of conversion
// requests feeds a stream driver with random gaps. The expected date, day
// number, weekday and before-epoch flag are computed in the testbench and
// checked word by word against the output stream, which stalls at random.
// The registers are reprogrammed between phases, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hadc_pkg::*;

  typedef struct {
    logic               cmd;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [ABS_W-1:0]   abs_day;
  } conv_req_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [21:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // in_year, in_month, in_day, in_abs_day, zero pad
  logic        in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // out_year, out_month, out_day, out_abs_day, weekday
  logic        out_tuser;  // before_epoch

  hijri_absolute_day_converter dut (.*);

  // register mirror
  longint unsigned r_epoch, r_num, r_den, r_off;

  conv_req_t pending[$];
  res_t      expected[$];
  conv_req_t cur_word;
  int        in_gap, out_gap, errors;
  bit        sender_hold;
  bit        drv_busy, mon_ready;

  function automatic longint unsigned cycle_len();
    return (r_den == 0) ? 64'd12 : r_den;
  endfunction

  function automatic longint unsigned month_len(input longint unsigned n);
    return (((n + r_off) * r_num) % cycle_len()) < r_num ? 64'd30 : 64'd29;
  endfunction

  function automatic longint unsigned days_into_year(input longint unsigned y,
                                                     input longint unsigned m);
    longint unsigned first, sum;
    first = (y - 1) * 12 + 1;
    sum = 0;
    for (longint unsigned k = 1; k < m; k++) sum += month_len(first + k - 1);
    return sum;
  endfunction

  function automatic longint unsigned day_number(input longint unsigned y,
                                                 input longint unsigned m,
                                                 input longint unsigned d);
    longint unsigned q, mc, rest, dc;
    q = cycle_len();
    mc = (y - 1) * 12;
    mc -= mc % q;
    rest = y - mc / 12;
    dc = r_epoch + mc * 29 + (mc * r_num) / q;
    for (longint unsigned i = 1; i < rest; i++) dc += days_into_year(i, 13);
    dc += days_into_year(y, m) + d;
    return dc - 1;
  endfunction

  function automatic res_t convert(input conv_req_t w);
    res_t r;
    longint unsigned ab, q, mc, y, m, d0, oa;
    r = '0;
    ab = w.abs_day;
    if (w.cmd == CMD_TO_ABS) begin
      oa = day_number((w.year == 0) ? 64'd1 : 64'(w.year), w.month, w.day) & 64'h3FFFFF;
      r.year = w.year;
      r.month = w.month;
      r.day = w.day;
      r.pre_epoch = oa < r_epoch;
    end else begin
      oa = ab;
      if (ab < r_epoch) begin
        r.pre_epoch = 1'b1;
      end else begin
        q = cycle_len();
        mc = ((ab - r_epoch + 1) * q) / (29 * q + r_num);
        y = mc / 12 + 1;
        m = mc % 12 + 1;
        d0 = day_number(y, m, 1);
        if (ab < d0) begin
          m--;
          if (m == 0) begin
            y--;
            m = 12;
          end
          d0 -= month_len((y - 1) * 12 + m);
        end
        r.year = y[YEAR_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.day = 5'(1 + ab - d0);
      end
    end
    r.abs_day = oa[ABS_W-1:0];
    r.weekday = 3'(oa % 7);
    return r;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      drv_busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected.push_back(convert(cur_word));
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!sender_hold && pending.size() > 0) begin
          cur_word = pending.pop_front();
          in_tdata <= {3'b0, cur_word.abs_day, cur_word.day, cur_word.month, cur_word.year};
          in_tuser <= cur_word.cmd;
          drv_busy = 1'b1;
          in_gap = rand_gap();
        end
      end
      in_tvalid <= drv_busy;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected.size() == 0) begin
          $display("%0t unexpected word: actual %h/%b", $realtime, out_tdata, out_tuser);
          errors++;
        end else begin
          res_t e;
          e = expected.pop_front();
          if (out_tdata[13:0] !== e.year || out_tdata[17:14] !== e.month ||
              out_tdata[22:18] !== e.day || out_tdata[44:23] !== e.abs_day ||
              out_tdata[47:45] !== e.weekday || out_tuser !== e.pre_epoch) begin
            $display("%0t mismatch: expected y=%0d m=%0d d=%0d abs=%0d wd=%0d be=%0b",
                     $realtime, e.year, e.month, e.day, e.abs_day, e.weekday, e.pre_epoch);
            $display("%0t           actual   y=%0d m=%0d d=%0d abs=%0d wd=%0d be=%0b",
                     $realtime, out_tdata[13:0], out_tdata[17:14], out_tdata[22:18],
                     out_tdata[44:23], out_tdata[47:45], out_tuser);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        mon_ready = 1'b0;
      end else begin
        mon_ready = 1'b1;
        out_gap = rand_gap();
      end
      out_tready <= mon_ready;
    end
  end

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || in_tvalid || expected.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_EPOCH:  r_epoch = val;
      REG_NUM:    r_num = val[9:0];
      REG_DEN:    r_den = val[9:0];
      default:    r_off = val[9:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [21:0] ep, input logic [9:0] p,
                              input logic [9:0] q, input logic [9:0] off);
    write_reg(REG_EPOCH, ep);
    write_reg(REG_NUM, {12'b0, p});
    write_reg(REG_DEN, {12'b0, q});
    write_reg(REG_OFFSET, {12'b0, off});
  endtask

  task automatic push_req(input logic c, input int y, input int m, input int d,
                          input longint unsigned a);
    conv_req_t w;
    w.cmd = c;
    w.year = y[YEAR_W-1:0];
    w.month = m[MONTH_W-1:0];
    w.day = d[DAY_W-1:0];
    w.abs_day = a[ABS_W-1:0];
    pending.push_back(w);
  endtask

  // mostly well-formed requests, some out-of-range noise
  task automatic fill_random(input int count);
    longint unsigned a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 9) == 0)
          push_req(CMD_TO_ABS, $urandom, $urandom, $urandom, $urandom);
        else
          push_req(CMD_TO_ABS, $urandom_range(1, 9999), $urandom_range(1, 12),
                   $urandom_range(1, 30), $urandom);
      end else begin
        a = r_epoch + $urandom_range(0, 3600000);
        if ($urandom_range(0, 9) == 0 || a > 64'h3FFFFF) a = $urandom;
        push_req(CMD_TO_DATE, $urandom, $urandom, $urandom, a);
      end
    end
  endtask

  initial begin
    sender_hold = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    r_epoch = 227015;
    r_num = 191;
    r_den = 360;
    r_off = 48;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, epoch boundary, odd dates
    push_req(CMD_TO_ABS, 1, 1, 1, 0);
    push_req(CMD_TO_ABS, 9999, 12, 30, 64'h3FFFFF);
    push_req(CMD_TO_ABS, 0, 1, 1, 0);
    push_req(CMD_TO_ABS, 16383, 15, 31, 0);
    push_req(CMD_TO_ABS, 1445, 0, 0, 0);
    push_req(CMD_TO_ABS, 1445, 13, 15, 0);
    push_req(CMD_TO_ABS, 30, 12, 30, 0);
    push_req(CMD_TO_ABS, 31, 1, 1, 0);
    push_req(CMD_TO_ABS, 7000, 6, 31, 0);
    push_req(CMD_TO_DATE, 0, 0, 0, 0);
    push_req(CMD_TO_DATE, 16383, 15, 31, 227014);
    push_req(CMD_TO_DATE, 0, 0, 0, 227015);
    push_req(CMD_TO_DATE, 0, 0, 0, 227016);
    push_req(CMD_TO_DATE, 0, 0, 0, 227015 + 29);
    push_req(CMD_TO_DATE, 0, 0, 0, 227015 + 354);
    push_req(CMD_TO_DATE, 0, 0, 0, 64'h3FFFFF);
    push_req(CMD_TO_DATE, 0, 0, 0, 64'h2AAAAA);
    push_req(CMD_TO_DATE, 0, 0, 0, 64'h155555);
    fill_random(300);
    wait (pending.size() < 150);
    // let the block drain completely once while items are still waiting
    sender_hold = 1'b1;
    wait (!in_tvalid && expected.size() == 0);
    repeat (10) @(posedge clk);
    sender_hold = 1'b0;
    fill_random(100);
    wait_idle();

    program_regs(22'd0, 10'd1, 10'd12, 10'd0);
    fill_random(200);
    wait_idle();

    program_regs(22'h3FFFFF, 10'd1023, 10'd1020, 10'd1023);
    fill_random(40);
    wait_idle();

    // zero denominator acts as 12
    program_regs(22'($urandom_range(0, 400000)), 10'd11, 10'd0, 10'($urandom));
    fill_random(200);
    wait_idle();

    program_regs(22'd1000, 10'd37, 10'd100, 10'd5);
    fill_random(150);
    wait_idle();

    program_regs(22'h2AAAAA, 10'($urandom_range(1, 1023)), 10'd24, 10'd512);
    fill_random(200);
    wait_idle();

    program_regs(22'd227015, 10'd191, 10'd360, 10'd48);
    fill_random(300);
    wait_idle();
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

endmodule
